[rtl/lzbp_pkg.sv]
package lzbp_pkg;

  localparam int SYM_W         = 8;
  localparam int CODE_W        = 16;
  localparam int CBITS_W       = 5;
  localparam int MAX_CODE_BITS = 16;
  localparam int CODE_LIMIT    = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam int PEND_W        = 7;
  localparam int PCNT_W        = 3;
  localparam int ACC_W         = PEND_W + SYM_W + CODE_W;
  localparam int TOT_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int MAX_BYTES     = 3;
  localparam int BYTES_W       = BYTE_W * MAX_BYTES;
  localparam int BCNT_W        = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic MODE_PAIR  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [BCNT_W-1:0]  cnt;
  } job_t;

endpackage

[rtl/lzbp_ifs.sv]
interface lzbp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  symbol;
  logic [15:0] code;
  logic [4:0]  code_bits;

  modport source (output valid, mode, symbol, code, code_bits, input ready);
  modport sink   (input valid, mode, symbol, code, code_bits, output ready);
endinterface

interface lzbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

[rtl/lz78_pair_bit_packer_unit.sv]
// Channel  | Dir | Payload                            | Handshake
// in_ch    | in  | mode, symbol, code, code_bits      | valid/ready
// out_ch   | out | out_byte, last                     | valid/ready
//
// One item is taken per cycle while the job queue has room; a pair yields
// one to three bytes, so the sustained rate is set by the one-byte-per-cycle
// output stage, which holds its byte while out_ch.ready is low.
// An item's bytes pass through the job queue and the output register.
// Synchronous active-low reset clears the pending bits, queue and output.
// Output stalls back up through the queue into in_ch.ready.
module lz78_pair_bit_packer_unit #(
  parameter int QUEUE_DEPTH = lzbp_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  lzbp_in_if.sink    in_ch,
  lzbp_out_if.source out_ch
);
  import lzbp_pkg::*;

  logic   q_push, q_full;
  job_t   f_job, q_job;
  logic   q_valid, q_pop;

  lzbp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_mode      (in_ch.mode),
    .in_symbol    (in_ch.symbol),
    .in_code      (in_ch.code),
    .in_code_bits (in_ch.code_bits),
    .q_push       (q_push),
    .q_full       (q_full),
    .job          (f_job)
  );

  lzbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .full       (q_full),
    .wr_job     (f_job),
    .rd_valid   (q_valid),
    .pop        (q_pop),
    .rd_job     (q_job)
  );

  lzbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last)
  );

endmodule

[rtl/lzbp_front.sv]
module lzbp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [lzbp_pkg::SYM_W-1:0]    in_symbol,
  input  logic [lzbp_pkg::CODE_W-1:0]   in_code,
  input  logic [lzbp_pkg::CBITS_W-1:0]  in_code_bits,
  output logic                          q_push,
  input  logic                          q_full,
  output lzbp_pkg::job_t                job
);
  import lzbp_pkg::*;

  logic [PEND_W-1:0]  pend_r, pend_nxt;
  logic [PCNT_W-1:0]  pcnt_r, pcnt_nxt;
  logic [CBITS_W-1:0] nbits;
  logic [CODE_W:0]    mask;
  logic [CODE_W-1:0]  code_m;
  logic [ACC_W-1:0]   acc, rest;
  logic [TOT_W-1:0]   total;
  logic [BCNT_W-1:0]  nbytes;
  logic [PEND_W:0]    pmask;
  logic               accept;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  always_comb begin
    nbits  = (in_code_bits > CBITS_W'(CODE_LIMIT)) ? CBITS_W'(CODE_LIMIT) : in_code_bits;
    mask   = ((CODE_W+1)'(1) << nbits) - (CODE_W+1)'(1);
    code_m = in_code & mask[CODE_W-1:0];
    acc    = ACC_W'(pend_r) | (ACC_W'(in_symbol) << pcnt_r)
           | (ACC_W'(code_m) << (ACC_W'(pcnt_r) + ACC_W'(SYM_W)));
    total  = TOT_W'(pcnt_r) + TOT_W'(SYM_W) + nbits;
    nbytes = total[TOT_W-1:3];
    rest   = acc >> {nbytes, 3'b000};
    pmask  = ((PEND_W+1)'(1) << total[2:0]) - (PEND_W+1)'(1);

    if (in_mode == MODE_FLUSH) begin
      job.bytes = BYTES_W'(pend_r);
      job.cnt   = (pcnt_r != '0) ? BCNT_W'(1) : BCNT_W'(0);
      pend_nxt  = '0;
      pcnt_nxt  = '0;
    end else begin
      job.bytes = acc[BYTES_W-1:0];
      job.cnt   = nbytes;
      pend_nxt  = rest[PEND_W-1:0] & pmask[PEND_W-1:0];
      pcnt_nxt  = total[2:0];
    end

    q_push = accept & (job.cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

endmodule

[rtl/lzbp_queue.sv]
module lzbp_queue #(
  parameter int DEPTH = lzbp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  lzbp_pkg::job_t    wr_job,
  output logic              rd_valid,
  input  logic              pop,
  output lzbp_pkg::job_t    rd_job
);
  import lzbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/lzbp_back.sv]
module lzbp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  lzbp_pkg::job_t               q_job,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lzbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_last
);
  import lzbp_pkg::*;

  logic               busy_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [BCNT_W-1:0]  cnt_r;
  logic               final_byte, take;

  assign final_byte = (cnt_r == BCNT_W'(1));
  assign take       = busy_r & out_ready;
  assign pop        = q_valid & (~busy_r | (take & final_byte));
  assign out_valid  = busy_r;
  assign out_byte   = bytes_r[BYTE_W-1:0];
  assign out_last   = final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (pop) begin
      busy_r <= 1'b1;
    end else if (take && final_byte) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bytes_r <= q_job.bytes;
      cnt_r   <= q_job.cnt;
    end else if (take && !final_byte) begin
      bytes_r <= bytes_r >> BYTE_W;
      cnt_r   <= cnt_r - BCNT_W'(1);
    end
  end

endmodule

[rtl/lzbp_checker.sv]
module lzbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import lzbp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid & in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("out item changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid right after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("in not ready right after reset");

  a_pair_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_mode == MODE_PAIR |-> ##2 out_valid)
    else $error("pair produced no byte");

endmodule

bind lz78_pair_bit_packer_unit lzbp_checker u_lzbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);
